// ----- src/rbsi_pkg.sv -----
// ----------------------------------------------------------------------------
// Ray box slab intersect package
// Shared types and constants for the 2D ray and box slab test pipeline.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_START_X = 2'd0,
        REG_START_Y = 2'd1,
        REG_DIR_X   = 2'd2,
        REG_DIR_Y   = 2'd3
    } t_reg_idx;

    // Quotient bits resolved per divider stage, and the stage count.
    localparam int unsigned QBITS       = 32;
    localparam int unsigned BITS_PER_ST = 4;
    localparam int unsigned DIV_STAGES  = QBITS / BITS_PER_ST;

    // Distances are carried as 34-bit signed values; infinity sits outside
    // the saturated 32-bit range.
    localparam logic signed [33:0] T_INF   = 34'sh1_0000_0000;
    localparam logic signed [33:0] T_NINF  = -34'sh1_0000_0000;
    localparam logic signed [33:0] SAT_HI  = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SAT_LO  = -34'sh0_8000_0000;

    localparam logic [1:0] HIT_NONE  = 2'd0;
    localparam logic [1:0] HIT_TOUCH = 2'd1;
    localparam logic [1:0] HIT_SPAN  = 2'd2;

    // One divider lane: partial remainder, shifting dividend and quotient.
    typedef struct packed {
        logic [15:0] rem;
        logic [31:0] w;
        logic        neg;
        logic        ovf;
    } t_lane;

    // One item in flight: lanes x-min, x-max, y-min, y-max and axis flags.
    typedef struct packed {
        t_lane [3:0] lane;
        logic  [1:0] dzero;
        logic  [1:0] in_slab;
    } t_item;

endpackage

// ----- src/ray_box_slab_intersect_2d.sv -----
// Throughput: one box per cycle; o_busy stays low, so start may be held high.
// The divider resolves the 32-bit quotient 4 bits per stage over
// 8 pipelined divider stages per lane, with four lanes side by side.
// Reset (synchronous, active low) clears all valid bits and loads the ray
// registers with start (0, 0) and direction (1.0, 0). The receiver cannot stall.
// ----------------------------------------------------------------------------
// Ray box slab intersect (2D)
// Pipelined fixed-point slab test of one axis-aligned box per cycle against
// a configured ray.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_2d (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_box_min_x,
    input  logic [31:0] i_box_min_y,
    input  logic [31:0] i_box_max_x,
    input  logic [31:0] i_box_max_y,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  rbsi_pkg::t_reg_idx i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_hit_count,
    output logic [30:0] o_t_enter,
    output logic [30:0] o_t_exit
);
    import rbsi_pkg::*;

    // Configuration registers.
    logic signed [31:0] r_start_x, r_start_y;
    logic signed [15:0] r_dir_x, r_dir_y;

    // Stage 0: captured box.
    logic               r_v0;
    logic signed [31:0] r_bnd [4];

    // Stage 1 and divider stages.
    logic               r_v1;
    t_item              r_prep;
    t_item              n_prep;
    logic  [DIV_STAGES-1:0] r_dv;
    t_item              r_div [DIV_STAGES];
    t_item              n_div [DIV_STAGES];

    // Saturation stage.
    logic               r_vs;
    logic signed [33:0] r_lo [2];
    logic signed [33:0] r_hi [2];
    logic signed [33:0] n_lo [2];
    logic signed [33:0] n_hi [2];

    // Output stage.
    logic        r_vo;
    logic [1:0]  r_cnt;
    logic [30:0] r_te, r_tx;
    logic [1:0]  n_cnt;
    logic [30:0] n_te, n_tx;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_dir_x   <= 16'sd16384;
            r_dir_y   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_X: r_start_x <= i_cfg_data;
                REG_START_Y: r_start_y <= i_cfg_data;
                REG_DIR_X:   r_dir_x   <= i_cfg_data[15:0];
                REG_DIR_Y:   r_dir_y   <= i_cfg_data[15:0];
                default:     r_dir_y   <= r_dir_y;
            endcase
        end
    end

    // Divisor magnitudes and signs per axis.
    logic [15:0] dmag [2];
    logic        dneg [2];
    always_comb begin
        dneg[0] = r_dir_x[15];
        dneg[1] = r_dir_y[15];
        dmag[0] = dneg[0] ? 16'(-r_dir_x) : 16'(r_dir_x);
        dmag[1] = dneg[1] ? 16'(-r_dir_y) : 16'(r_dir_y);
    end

    // Stage 1: differences, magnitudes, overflow check, zero-direction and in-slab tests.
    always_comb begin
        logic signed [32:0] diff;
        logic        [32:0] mag;
        logic signed [31:0] s;
        logic signed [31:0] bl, bh;
        logic ax;
        n_prep = '0;
        for (int l = 0; l < 4; l++) begin
            ax   = l[1];
            s    = (ax == 1'b0) ? r_start_x : r_start_y;
            diff = 33'(r_bnd[l]) - 33'(s);
            mag  = diff[32] ? 33'(-diff) : 33'(diff);
            n_prep.lane[l].neg = diff[32] ^ dneg[ax];
            n_prep.lane[l].ovf = {1'b0, mag[32:18]} >= dmag[ax];
            n_prep.lane[l].rem = {1'b0, mag[32:18]};
            n_prep.lane[l].w   = {mag[17:0], 14'b0};
        end
        for (int a = 0; a < 2; a++) begin
            s  = (a == 0) ? r_start_x : r_start_y;
            bl = (r_bnd[2*a] < r_bnd[2*a+1]) ? r_bnd[2*a] : r_bnd[2*a+1];
            bh = (r_bnd[2*a] < r_bnd[2*a+1]) ? r_bnd[2*a+1] : r_bnd[2*a];
            n_prep.dzero[a]   = (dmag[a] == 16'd0);
            n_prep.in_slab[a] = (s >= bl) && (s <= bh);
        end
    end

    // Divider stages: restoring division, several quotient bits per stage.
    always_comb begin
        t_item       cur;
        logic [16:0] r17;
        for (int st = 0; st < DIV_STAGES; st++) begin
            cur = (st == 0) ? r_prep : r_div[st-1];
            for (int l = 0; l < 4; l++) begin
                for (int k = 0; k < BITS_PER_ST; k++) begin
                    r17 = {cur.lane[l].rem, cur.lane[l].w[31]};
                    if (r17 >= {1'b0, dmag[l/2]}) begin
                        cur.lane[l].rem = 16'(r17 - {1'b0, dmag[l/2]});
                        cur.lane[l].w   = {cur.lane[l].w[30:0], 1'b1};
                    end else begin
                        cur.lane[l].rem = r17[15:0];
                        cur.lane[l].w   = {cur.lane[l].w[30:0], 1'b0};
                    end
                end
            end
            n_div[st] = cur;
        end
    end

    // Saturation and per-axis slab interval.
    always_comb begin
        t_item              f;
        logic signed [33:0] t [4];
        f = r_div[DIV_STAGES-1];
        for (int l = 0; l < 4; l++) begin
            if (!f.lane[l].neg) begin
                t[l] = (f.lane[l].ovf || f.lane[l].w[31]) ? SAT_HI
                                                          : {2'b00, f.lane[l].w};
            end else if (f.lane[l].ovf || (f.lane[l].w > 32'h8000_0000)) begin
                t[l] = SAT_LO;
            end else begin
                t[l] = -$signed({2'b00, f.lane[l].w});
            end
        end
        for (int a = 0; a < 2; a++) begin
            if (f.dzero[a]) begin
                n_lo[a] = f.in_slab[a] ? T_NINF : T_INF;
                n_hi[a] = f.in_slab[a] ? T_INF  : T_NINF;
            end else begin
                n_lo[a] = (t[2*a] < t[2*a+1]) ? t[2*a] : t[2*a+1];
                n_hi[a] = (t[2*a] < t[2*a+1]) ? t[2*a+1] : t[2*a];
            end
        end
    end

    // Entry, exit and hit count.
    always_comb begin
        logic signed [33:0] ent, lv;
        ent = (r_lo[0] > r_lo[1]) ? r_lo[0] : r_lo[1];
        if (ent < 0) begin
            ent = '0;
        end
        lv = (r_hi[0] < r_hi[1]) ? r_hi[0] : r_hi[1];
        n_cnt = HIT_NONE;
        n_te  = '0;
        n_tx  = '0;
        if (ent <= lv) begin
            n_cnt = (ent < lv) ? HIT_SPAN : HIT_TOUCH;
            n_te  = (ent > SAT_HI) ? 31'h7FFF_FFFF : ent[30:0];
            n_tx  = (lv > SAT_HI) ? 31'h7FFF_FFFF : lv[30:0];
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_dv <= '0;
            r_vs <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v0 <= i_start;
            r_v1 <= r_v0;
            r_dv <= {r_dv[DIV_STAGES-2:0], r_v1};
            r_vs <= r_dv[DIV_STAGES-1];
            r_vo <= r_vs;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bnd[0] <= i_box_min_x;
            r_bnd[1] <= i_box_max_x;
            r_bnd[2] <= i_box_min_y;
            r_bnd[3] <= i_box_max_y;
        end
        r_prep <= n_prep;
        for (int st = 0; st < DIV_STAGES; st++) begin
            r_div[st] <= n_div[st];
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_cnt <= n_cnt;
        r_te  <= n_te;
        r_tx  <= n_tx;
    end

    assign o_valid     = r_vo;
    assign o_hit_count = r_cnt;
    assign o_t_enter   = r_te;
    assign o_t_exit    = r_tx;

`ifndef SYNTHESIS
    // Each accepted box gives a result after the fixed pipeline latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> ##11 o_valid)
        else $error("result strobe missing after start");

    // A strobe only comes from an accepted box.
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 12))
        else $error("result strobe without a start");

    // A miss reports zero distances.
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_count == HIT_NONE) |-> (o_t_enter == 31'd0 && o_t_exit == 31'd0))
        else $error("miss with nonzero distance");

    // A touch reports equal entry and exit.
    a_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_count == HIT_TOUCH) |-> (o_t_enter == o_t_exit))
        else $error("touch with differing distances");
`endif

endmodule
